@@ hw/rtl/rfp_pkg.sv @@
`default_nettype none

package rfp_pkg;

  // Field widths of the ports
  localparam int unsigned RAD_W   = 10;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned CH_W    = 8;

  // Radius saturates here
  localparam int unsigned MAX_RADIUS = 512;

  localparam int unsigned SAT_W  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned R2_W   = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
  localparam int unsigned D2_W   = 2 * SAT_W + 1;
  localparam int unsigned CMP_W  = ((SAT_W > COORD_W) ? SAT_W : COORD_W) + 2;
  localparam int unsigned PROD_W = CH_W + R2_W;

  // One restoring step per quotient bit
  localparam int unsigned DIV_STAGES = CH_W;

  localparam int unsigned RADIUS_RESET = 64;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_COLOR  = 2'd1
  } cfg_index_e;

endpackage

`default_nettype wire

@@ hw/rtl/rfp_divider.sv @@
`default_nettype none

module rfp_divider
  import rfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [PROD_W-1:0] dividend_i,
  input  wire logic [R2_W-1:0]   divisor_i,
  output logic      [CH_W-1:0]   quot_o
);

  // Quotient is known to stay below 2**CH_W, so DIV_STAGES steps suffice.
  logic [PROD_W-1:0] rem_q [DIV_STAGES];
  logic [CH_W-1:0]   quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    logic [PROD_W-1:0] rem_in;
    logic [CH_W-1:0]   quo_in;
    logic [PROD_W-1:0] shifted;
    logic [PROD_W:0]   diff;
    logic [PROD_W-1:0] rem_d;
    logic [CH_W-1:0]   quo_d;

    always_comb begin
      if (j == 0) begin
        rem_in = dividend_i;
        quo_in = '0;
      end else begin
        rem_in = rem_q[(j == 0) ? 0 : j - 1];
        quo_in = quo_q[(j == 0) ? 0 : j - 1];
      end
      shifted = PROD_W'(divisor_i) << (DIV_STAGES - 1 - j);
      diff    = {1'b0, rem_in} - {1'b0, shifted};
      // keep the trial difference when it did not borrow
      if (!diff[PROD_W]) begin
        rem_d = diff[PROD_W-1:0];
        quo_d = {quo_in[CH_W-2:0], 1'b1};
      end else begin
        rem_d = rem_in;
        quo_d = {quo_in[CH_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quot_o = quo_q[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ hw/rtl/radial_falloff_pixel_rgb565.sv @@
// Throughput: one pixel per cycle; the whole pipeline advances together and halts
// only while the output register holds a beat under out_stall_i.
// Pipeline: bounds and offsets, squares, distance compare, channel products,
// eight restoring divide steps by R*R, pack. Reset clears all valid bits and loads
// radius 64 and color 0xFFFFFF; no pixel is in flight after reset.
`default_nettype none

module radial_falloff_pixel_rgb565
  import rfp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [COORD_W-1:0]   pixel_x_i,
  input  wire logic [COORD_W-1:0]   pixel_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [PIX_W-1:0]     pixel_value_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COLOR_W-1:0]   cfg_data_i
);

  logic               adv;
  logic [RAD_W-1:0]   radius_q;
  logic [COLOR_W-1:0] color_q;
  logic [R2_W-1:0]    r2_q, r2_d;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(RADIUS_RESET);
      color_q  <= COLOR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_COLOR:  color_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Stage 1: saturate radius, border test, absolute offsets
  logic [CMP_W-1:0]   rad_ext, r_ext, lim_ext, x_ext, y_ext, dx_ext, dy_ext;
  logic [CMP_W-1:0]   adx_ext, ady_ext;
  logic [SAT_W-1:0]   r_sat;
  logic [2*SAT_W-1:0] r2_full;
  logic               z1_d;

  always_comb begin
    rad_ext = CMP_W'(radius_q);
    r_ext   = (rad_ext > CMP_W'(MAX_RADIUS)) ? CMP_W'(MAX_RADIUS) : rad_ext;
    r_sat   = r_ext[SAT_W-1:0];
    lim_ext = (r_ext << 1) - CMP_W'(1);
    x_ext   = CMP_W'(pixel_x_i);
    y_ext   = CMP_W'(pixel_y_i);
    z1_d    = (r_ext < CMP_W'(2)) || (x_ext == '0) || (y_ext == '0) ||
              (x_ext >= lim_ext) || (y_ext >= lim_ext);
    dx_ext  = r_ext - x_ext;
    dy_ext  = r_ext - y_ext;
    adx_ext = dx_ext[CMP_W-1] ? (CMP_W'(0) - dx_ext) : dx_ext;
    ady_ext = dy_ext[CMP_W-1] ? (CMP_W'(0) - dy_ext) : dy_ext;
    r2_full = (2*SAT_W)'(r_sat) * (2*SAT_W)'(r_sat);
    r2_d    = r2_full[R2_W-1:0];
  end

  // R*R tracks radius_q; the user, not the block, keeps config idle long before use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= R2_W'(RADIUS_RESET * RADIUS_RESET);
    end else begin
      r2_q <= r2_d;
    end
  end

  logic             v1_q, z1_q;
  logic [SAT_W-1:0] adx_q, ady_q;

  // Stage 2: squares
  logic                v2_q, z2_q;
  logic [2*SAT_W-1:0]  sqx_q, sqy_q;

  // Stage 3: distance compare and numerator
  logic [D2_W-1:0]  d2;
  logic             z3_d;
  logic [R2_W-1:0]  num_d;
  logic             v3_q, z3_q;
  logic [R2_W-1:0]  num_q;

  always_comb begin
    d2    = D2_W'(sqx_q) + D2_W'(sqy_q);
    z3_d  = z2_q || (d2 >= D2_W'(r2_q));
    num_d = r2_q - d2[R2_W-1:0];
  end

  // Stage 4: channel products
  logic              v4_q, z4_q;
  logic [PROD_W-1:0] prod_r_q, prod_g_q, prod_b_q;

  // Divide stages carry valid and zero flags alongside
  logic [DIV_STAGES-1:0] vd_q, zd_q;

  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_q;

  // Advance everything when the output slot is free or being taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      vd_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      vd_q        <= {vd_q[DIV_STAGES-2:0], v4_q};
      out_valid_q <= vd_q[DIV_STAGES-1];
    end
  end

  logic [CH_W-1:0] quot_r, quot_g, quot_b;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z1_q     <= z1_d;
      adx_q    <= adx_ext[SAT_W-1:0];
      ady_q    <= ady_ext[SAT_W-1:0];
      z2_q     <= z1_q;
      sqx_q    <= (2*SAT_W)'(adx_q) * (2*SAT_W)'(adx_q);
      sqy_q    <= (2*SAT_W)'(ady_q) * (2*SAT_W)'(ady_q);
      z3_q     <= z3_d;
      num_q    <= num_d;
      z4_q     <= z3_q;
      prod_r_q <= PROD_W'(color_q[CH_W-1:0]) * PROD_W'(num_q);
      prod_g_q <= PROD_W'(color_q[2*CH_W-1:CH_W]) * PROD_W'(num_q);
      prod_b_q <= PROD_W'(color_q[3*CH_W-1:2*CH_W]) * PROD_W'(num_q);
      zd_q     <= {zd_q[DIV_STAGES-2:0], z4_q};
      // drop the low bits of each channel and pack 5:6:5
      if (zd_q[DIV_STAGES-1]) begin
        pixel_q <= '0;
      end else begin
        pixel_q <= {quot_b[CH_W-1:3], quot_g[CH_W-1:2], quot_r[CH_W-1:3]};
      end
    end
  end

  rfp_divider u_div_r (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (prod_r_q),
    .divisor_i  (r2_q),
    .quot_o     (quot_r)
  );

  rfp_divider u_div_g (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (prod_g_q),
    .divisor_i  (r2_q),
    .quot_o     (quot_g)
  );

  rfp_divider u_div_b (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (prod_b_q),
    .divisor_i  (r2_q),
    .quot_o     (quot_b)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;

endmodule

`default_nettype wire

@@ hw/rtl/rfp_checker.sv @@
`default_nettype none

module rfp_checker
  import rfp_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic [COORD_W-1:0]   pixel_x_i,
  input wire logic [COORD_W-1:0]   pixel_y_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [PIX_W-1:0]     pixel_value_o,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [COLOR_W-1:0]   cfg_data_i
);

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o))
    else $error("output beat changed while stalled");

  // input backs up only behind a stalled output beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // nothing in flight right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // a stalled config write never appears
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind radial_falloff_pixel_rgb565 rfp_checker u_rfp_checker (.*);

`default_nettype wire

@@ verif/radial_falloff_pixel_rgb565_test.sv @@
`default_nettype none

module radial_falloff_pixel_rgb565_test
  import rfp_pkg::*;
;

  // Indexes past the register list; writes to them must not change anything
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 30;
  localparam int unsigned COORD_MAX      = (1 << COORD_W) - 1;

  class pixel_scoreboard;
    logic [RAD_W-1:0]   radius;
    logic [COLOR_W-1:0] color;
    logic [PIX_W-1:0]   pixel_q[$];
    int                 failures;

    function new();
      radius   = RAD_W'(RADIUS_RESET);
      color    = COLOR_RESET;
      failures = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
      case (idx)
        CFG_RADIUS: radius = data[RAD_W-1:0];
        CFG_COLOR:  color = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamped_radius();
      return (32'(radius) > MAX_RADIUS) ? MAX_RADIUS : 32'(radius);
    endfunction

    function logic [CH_W-1:0] attenuate(logic [CH_W-1:0] c, longint unsigned num,
                                        longint unsigned den);
      longint unsigned prod;
      prod = 64'(c);
      prod = (prod * num) / den;
      return prod[CH_W-1:0];
    endfunction

    function logic [PIX_W-1:0] falloff_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int unsigned r, side, r2, d2, num;
      int dx, dy;
      logic [CH_W-1:0] red, green, blue;
      r = clamped_radius();
      if (r < 2) return '0;
      side = 2 * r;
      if (x == '0 || y == '0 || 32'(x) >= side - 1 || 32'(y) >= side - 1) return '0;
      dx = int'(r) - int'(x);
      dy = int'(r) - int'(y);
      d2 = dx * dx + dy * dy;
      r2 = r * r;
      if (d2 >= r2) return '0;
      num   = r2 - d2;
      red   = attenuate(color[7:0], num, r2);
      green = attenuate(color[15:8], num, r2);
      blue  = attenuate(color[23:16], num, r2);
      return {blue[7:3], green[7:2], red[7:3]};
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      pixel_q.push_back(falloff_pixel(x, y));
    endfunction

    function void check_pixel(logic [PIX_W-1:0] got);
      logic [PIX_W-1:0] want;
      if (pixel_q.size() == 0) begin
        $error("pixel_value: expected none, actual %h", got);
        failures++;
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) begin
          $error("pixel_value: expected %h, actual %h", want, got);
          failures++;
        end
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [COORD_W-1:0]   pixel_x_i = '0;
  logic [COORD_W-1:0]   pixel_y_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     pixel_value_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COLOR_W-1:0]   cfg_data_i = '0;

  int unsigned tx_idle_pct = 12;
  int unsigned rx_stall_pct = 52;
  int unsigned idle_cycles = 0;

  pixel_scoreboard board = new();

  radial_falloff_pixel_rgb565 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99, 0) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_pixel(pixel_value_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_pixel(int unsigned x, int unsigned y);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= x[COORD_W-1:0];
    pixel_y_i  <= y[COORD_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    board.note_pixel(x[COORD_W-1:0], y[COORD_W-1:0]);
  endtask

  task automatic drain();
    while (board.pending() > 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.note_config(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprogram while idle, then run a burst of mostly in-map pixels
  task automatic run_phase(int unsigned radius, logic [COLOR_W-1:0] color, int unsigned count);
    int unsigned span, x, y;
    drain();
    cfg_write(CFG_RADIUS, {14'($urandom()), radius[RAD_W-1:0]});
    cfg_write(CFG_COLOR, color);
    cfg_write($urandom_range(1, 0) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom()));
    span = (board.clamped_radius() < 2) ? 8 : 2 * board.clamped_radius();
    if (span > COORD_MAX) span = COORD_MAX;
    repeat (count) begin
      if ($urandom_range(99, 0) < 80) begin
        x = $urandom_range(span, 0);
        y = $urandom_range(span, 0);
      end else begin
        x = $urandom_range(COORD_MAX, 0);
        y = $urandom_range(COORD_MAX, 0);
      end
      send_pixel(x, y);
    end
    in_valid_i <= 1'b0;
  endtask

  // Reset map: radius 64, so the border sits at 0 and 127 and the rim near d2 = 4096
  int unsigned edge_x[] = '{0, 1, 0, 64, 127, 64, 126, 64, 64, 63, 64, 1, 19, 18,
                            1023, 1023, 64, 512, 100, 33, 682, 341};
  int unsigned edge_y[] = '{0, 1, 64, 0, 64, 127, 64, 126, 64, 64, 1, 64, 19, 18,
                            1023, 64, 1023, 512, 100, 90, 341, 682};

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_x[i]) send_pixel(edge_x[i], edge_y[i]);
    in_valid_i <= 1'b0;

    run_phase(512, 24'hFFFFFF, 180);
    run_phase(1023, 24'($urandom()), 150);
    run_phase(513, 24'h000000, 100);
    run_phase(0, 24'hFFFFFF, 40);

    tx_idle_pct  = 52;
    rx_stall_pct = 12;
    run_phase(1, 24'hFFFFFF, 40);
    run_phase(2, 24'($urandom()), 80);
    run_phase(3, 24'hFFFFFF, 80);
    run_phase($urandom_range(511, 2), 24'($urandom()), 200);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_phase($urandom_range(64, 4), 24'($urandom()), 200);
    run_phase($urandom_range(511, 2), 24'($urandom()), 200);
    run_phase(64, 24'($urandom()), 200);
    run_phase($urandom_range(1023, 0), 24'($urandom()), 200);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ radial_falloff_pixel_rgb565.f @@
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_divider.sv
hw/rtl/radial_falloff_pixel_rgb565.sv
hw/rtl/rfp_checker.sv
verif/radial_falloff_pixel_rgb565_test.sv
